/* rtl/core/hcr_pkg.sv */
package hcr_pkg;

   localparam int HEIGHT_W    = 16;
   localparam int COLOR_W     = 24;
   localparam int CH_W        = 8;
   localparam int FRAC_BITS   = 16;
   // breaks up to 64, so a position below the top break fits in this width
   localparam int BREAK_W     = FRAC_BITS + 7;
   // channel steps are multiples of 2^STEP_LOG
   localparam int STEP_LOG    = 6;
   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_W     = 31;
   localparam int CSR_INDEX_W = 1;

   localparam int GROUP_TOTAL_DEF  = 10;
   localparam int FIRST_BREAK_DEF  = 2;
   localparam int SECOND_BREAK_DEF = 5;
   localparam int THIRD_BREAK_DEF  = 8;

   localparam logic [CH_W-1:0]    CH_ZERO    = 8'h00;
   localparam logic [CH_W-1:0]    CH_QUARTER = 8'h40;
   localparam logic [CH_W-1:0]    CH_HALF    = 8'h80;
   localparam logic [CH_W-1:0]    CH_THREE_Q = 8'hC0;
   localparam logic [CH_W-1:0]    CH_FULL    = 8'hFF;
   localparam logic [COLOR_W-1:0] RGB_WHITE  = 24'hFFFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEIGHT_MIN = 1'b0,
      CSR_HEIGHT_MAX = 1'b1
   } csr_index_type;

   // side information that travels with every request
   typedef struct packed {
      logic               has_color;
      logic [COLOR_W-1:0] given_color;
      logic               zero;    // position forced to 0
      logic               white;   // position beyond the quotient range or the top break
   } token_type;

endpackage

/* rtl/core/hcr_front.sv */
module hcr_front
   import hcr_pkg::*;
#(
   parameter int GROUP_TOTAL = GROUP_TOTAL_DEF,
   parameter int QUOT_INT_W  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  logic signed [HEIGHT_W-1:0] up_height,
   input  logic                       up_has_color,
   input  logic [COLOR_W-1:0]         up_given_color,
   input  logic signed [HEIGHT_W-1:0] height_min,
   input  logic signed [HEIGHT_W-1:0] height_max,
   input  logic [HEIGHT_W-1:0]        span,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output logic [HEIGHT_W-1:0]        dn_rem,
   output logic [FRAC_BITS+QUOT_INT_W-1:0] dn_dq,
   output token_type                  dn_tok
);

   localparam int QW = FRAC_BITS + QUOT_INT_W;
   localparam int GW = $clog2(GROUP_TOTAL + 1);
   localparam int NW = HEIGHT_W + GW;

   logic [HEIGHT_W:0]   diff;
   logic [NW-1:0]       scaled;
   logic                use_ramp;
   logic                ovf;
   logic                load;

   logic                valid_ff, valid_in;
   logic [HEIGHT_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]       dq_ff, dq_in;
   token_type           tok_ff, tok_in;

   assign diff     = {up_height[HEIGHT_W-1], up_height} - {height_min[HEIGHT_W-1], height_min};
   assign use_ramp = (height_max > height_min) && (up_height > height_min);
   assign scaled   = NW'(diff[HEIGHT_W-1:0]) * NW'(GROUP_TOTAL);
   // quotient would not fit in QW bits
   assign ovf      = (scaled >> QUOT_INT_W) >= NW'(span);
   assign load     = !valid_ff || dn_ready;
   assign up_ready = load;

   always_comb begin
      valid_in = load ? up_valid : valid_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      tok_in   = tok_ff;
      if (load && up_valid) begin
         rem_in             = HEIGHT_W'(scaled >> QUOT_INT_W);
         dq_in              = {scaled[QUOT_INT_W-1:0], FRAC_BITS'(0)};
         tok_in.has_color   = up_has_color;
         tok_in.given_color = up_given_color;
         tok_in.zero        = !use_ramp;
         tok_in.white       = use_ramp && ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      tok_ff <= tok_in;
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_dq    = dq_ff;
   assign dn_tok   = tok_ff;

endmodule

/* rtl/core/hcr_div_cell.sv */
module hcr_div_cell
   import hcr_pkg::*;
#(
   parameter int QUOT_W = FRAC_BITS + 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [HEIGHT_W-1:0] span,
   input  logic                up_valid,
   output logic                up_ready,
   input  logic [HEIGHT_W-1:0] up_rem,
   input  logic [QUOT_W-1:0]   up_dq,
   input  token_type           up_tok,
   output logic                dn_valid,
   input  logic                dn_ready,
   output logic [HEIGHT_W-1:0] dn_rem,
   output logic [QUOT_W-1:0]   dn_dq,
   output token_type           dn_tok
);

   // dq: unread dividend bits leave at the top, quotient bits enter at the bottom
   logic [HEIGHT_W:0]   trial;
   logic [HEIGHT_W:0]   less;
   logic                fits;
   logic                load;

   logic                valid_ff, valid_in;
   logic [HEIGHT_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]   dq_ff, dq_in;
   token_type           tok_ff, tok_in;

   assign trial    = {up_rem, up_dq[QUOT_W-1]};
   assign less     = trial - {1'b0, span};
   assign fits     = trial >= {1'b0, span};
   assign load     = !valid_ff || dn_ready;
   assign up_ready = load;

   always_comb begin
      valid_in = load ? up_valid : valid_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      tok_in   = tok_ff;
      if (load && up_valid) begin
         rem_in = fits ? less[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
         dq_in  = {up_dq[QUOT_W-2:0], fits};
         tok_in = up_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      tok_ff <= tok_in;
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_dq    = dq_ff;
   assign dn_tok   = tok_ff;

   // partial remainder stays below the divisor
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !tok_ff.zero && !tok_ff.white |-> rem_ff < span)
      else $error("remainder not below divisor");

   // a stalled cell keeps its request
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !dn_ready |=> valid_ff && $stable(dq_ff) && $stable(rem_ff))
      else $error("stalled cell lost its contents");

endmodule

/* rtl/core/hcr_shade.sv */
module hcr_shade
   import hcr_pkg::*;
#(
   parameter int FIRST_BREAK  = FIRST_BREAK_DEF,
   parameter int SECOND_BREAK = SECOND_BREAK_DEF,
   parameter int THIRD_BREAK  = THIRD_BREAK_DEF,
   parameter int QUOT_W       = FRAC_BITS + 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic [QUOT_W-1:0]  up_quot,
   input  token_type          up_tok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COLOR_W-1:0] rsp_rgb
);

   localparam int LEN_LOW  = FIRST_BREAK;
   localparam int LEN_MID  = (SECOND_BREAK > FIRST_BREAK) ? SECOND_BREAK - FIRST_BREAK : 1;
   localparam int LEN_HIGH = (THIRD_BREAK > SECOND_BREAK) ? THIRD_BREAK - SECOND_BREAK : 1;
   localparam int TW       = QUOT_W + RECIP_W;
   localparam int TXW      = TW + 2;
   localparam int RNUM_LOG = RECIP_SHIFT - FRAC_BITS + STEP_LOG;

   localparam logic [BREAK_W-1:0] BRK1 = BREAK_W'(FIRST_BREAK) << FRAC_BITS;
   localparam logic [BREAK_W-1:0] BRK2 = BREAK_W'(SECOND_BREAK) << FRAC_BITS;
   localparam logic [BREAK_W-1:0] BRK3 = BREAK_W'(THIRD_BREAK) << FRAC_BITS;
   localparam logic [BREAK_W-1:0] SPAN_LOW  = BREAK_W'(LEN_LOW) << FRAC_BITS;
   localparam logic [BREAK_W-1:0] SPAN_MID  = BREAK_W'(LEN_MID) << FRAC_BITS;
   localparam logic [BREAK_W-1:0] SPAN_HIGH = BREAK_W'(LEN_HIGH) << FRAC_BITS;

   // ceil(2^30 / L): exact floor of k*d / (L*2^10) after a 40-bit shift
   localparam logic [RECIP_W-1:0] RECIP_LOW =
      RECIP_W'(((64'd1 << RNUM_LOG) + 64'(LEN_LOW) - 64'd1) / 64'(LEN_LOW));
   localparam logic [RECIP_W-1:0] RECIP_MID =
      RECIP_W'(((64'd1 << RNUM_LOG) + 64'(LEN_MID) - 64'd1) / 64'(LEN_MID));
   localparam logic [RECIP_W-1:0] RECIP_HIGH =
      RECIP_W'(((64'd1 << RNUM_LOG) + 64'(LEN_HIGH) - 64'd1) / 64'(LEN_HIGH));

   typedef enum logic [1:0] {SEG_LOW, SEG_MID, SEG_HIGH, SEG_TOP} seg_type;

   logic                load_a, load_b, load_c;
   logic [BREAK_W-1:0]  pos;
   logic [BREAK_W-1:0]  offs;
   seg_type             seg;
   logic [RECIP_W-1:0]  recip;
   logic [BREAK_W-1:0]  span_sel;
   logic [TXW-1:0]      t2, t3;
   logic [CH_W-1:0]     q1, q2, q3;
   logic [COLOR_W-1:0]  rgb;

   logic                valid_a_ff, valid_a_in;
   seg_type             seg_a_ff, seg_a_in;
   logic [QUOT_W-1:0]   d_a_ff, d_a_in;
   token_type           tok_a_ff, tok_a_in;

   logic                valid_b_ff, valid_b_in;
   seg_type             seg_b_ff, seg_b_in;
   logic [TW-1:0]       t_b_ff, t_b_in;
   token_type           tok_b_ff, tok_b_in;

   logic                valid_c_ff, valid_c_in;
   logic [COLOR_W-1:0]  rgb_c_ff, rgb_c_in;

   assign load_c   = !valid_c_ff || rsp_ready;
   assign load_b   = !valid_b_ff || load_c;
   assign load_a   = !valid_a_ff || load_b;
   assign up_ready = load_a;

   // stage A: segment pick and offset inside the segment
   always_comb begin
      pos = up_tok.zero ? BREAK_W'(0) : BREAK_W'(up_quot);
      priority if (pos < BRK1) begin
         seg  = SEG_LOW;
         offs = pos;
      end else if (pos < BRK2) begin
         seg  = SEG_MID;
         offs = pos - BRK1;
      end else if (pos < BRK3) begin
         seg  = SEG_HIGH;
         offs = pos - BRK2;
      end else begin
         seg  = SEG_TOP;
         offs = BREAK_W'(0);
      end
   end

   always_comb begin
      valid_a_in = load_a ? up_valid : valid_a_ff;
      seg_a_in   = seg_a_ff;
      d_a_in     = d_a_ff;
      tok_a_in   = tok_a_ff;
      if (load_a && up_valid) begin
         seg_a_in       = seg;
         d_a_in         = QUOT_W'(offs);
         tok_a_in       = up_tok;
         tok_a_in.white = up_tok.white || (seg == SEG_TOP);
      end
   end

   // stage B: offset times reciprocal of the segment length
   always_comb begin
      unique case (seg_a_ff)
         SEG_LOW: begin
            recip    = RECIP_LOW;
            span_sel = SPAN_LOW;
         end
         SEG_MID: begin
            recip    = RECIP_MID;
            span_sel = SPAN_MID;
         end
         SEG_HIGH: begin
            recip    = RECIP_HIGH;
            span_sel = SPAN_HIGH;
         end
         SEG_TOP: begin
            recip    = RECIP_LOW;
            span_sel = SPAN_LOW;
         end
      endcase
   end

   always_comb begin
      valid_b_in = load_b ? valid_a_ff : valid_b_ff;
      seg_b_in   = seg_b_ff;
      t_b_in     = t_b_ff;
      tok_b_in   = tok_b_ff;
      if (load_b && valid_a_ff) begin
         seg_b_in = seg_a_ff;
         t_b_in   = TW'(d_a_ff) * TW'(recip);
         tok_b_in = tok_a_ff;
      end
   end

   // stage C: steps of one, two and three quarters, then the colour
   assign t2 = TXW'(t_b_ff) << 1;
   assign t3 = TXW'(t_b_ff) + t2;
   assign q1 = t_b_ff[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
   assign q2 = t2[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
   assign q3 = t3[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

   always_comb begin
      priority if (tok_b_ff.has_color) begin
         rgb = tok_b_ff.given_color;
      end else if (tok_b_ff.white) begin
         rgb = RGB_WHITE;
      end else begin
         unique case (seg_b_ff)
            SEG_LOW:  rgb = {CH_ZERO, CH_ZERO, CH_HALF + q2};
            SEG_MID:  rgb = {q1, q2, CH_FULL - q3};
            SEG_HIGH: rgb = {CH_QUARTER + q1, CH_THREE_Q - q2, CH_QUARTER - q1};
            SEG_TOP:  rgb = RGB_WHITE;
         endcase
      end
   end

   always_comb begin
      valid_c_in = load_c ? valid_b_ff : valid_c_ff;
      rgb_c_in   = (load_c && valid_b_ff) ? rgb : rgb_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_a_ff <= seg_a_in;
      d_a_ff   <= d_a_in;
      tok_a_ff <= tok_a_in;
      seg_b_ff <= seg_b_in;
      t_b_ff   <= t_b_in;
      tok_b_ff <= tok_b_in;
      rgb_c_ff <= rgb_c_in;
   end

   assign rsp_valid = valid_c_ff;
   assign rsp_rgb   = rgb_c_ff;

   // offset lies inside the chosen segment
   a_offs_in_seg: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff && !tok_a_ff.white |-> BREAK_W'(d_a_ff) < span_sel)
      else $error("offset outside its segment");

   // stage B moves into the output register when it is free
   a_b_to_c: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff && load_c |=> valid_c_ff)
      else $error("request dropped before output register");

   // explicit colour leaves untouched
   a_pass_color: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff && load_c && tok_b_ff.has_color |=> rsp_rgb == $past(tok_b_ff.given_color))
      else $error("explicit colour altered");

endmodule

/* rtl/core/height_to_color_ramp_unit.sv */
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------
// request   | req_tvalid/req_tready  | tdata: height[15:0], given_color[39:16];
//           |                        | tuser: has_color
// response  | rsp_tvalid/rsp_tready  | tdata: rgb[23:0] (0xRRGGBB)
// csr       | csr_we (no wait)       | csr_index, csr_wdata[15:0]
//
// One request per cycle sustained while rsp_tready stays high. The pipeline is
// one front stage, a row of QUOT_W restoring-divider cells that each settle one
// quotient bit, then three shading stages.
// Reset (synchronous) clears every valid bit and both height registers.
// Every stage has its own valid bit and loads when it is empty or its
// neighbour moves, so rsp_tready low fills the row before req_tready drops.
module height_to_color_ramp_unit
   import hcr_pkg::*;
#(
   parameter int GROUP_TOTAL  = GROUP_TOTAL_DEF,
   parameter int FIRST_BREAK  = FIRST_BREAK_DEF,
   parameter int SECOND_BREAK = SECOND_BREAK_DEF,
   parameter int THIRD_BREAK  = THIRD_BREAK_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [HEIGHT_W+COLOR_W-1:0] req_tdata,  // height, given_color
   input  logic                   req_tuser,       // has_color
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [COLOR_W-1:0]     rsp_tdata,       // rgb
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [HEIGHT_W-1:0]    csr_wdata
);

   // quotient wide enough for every position below the highest break
   localparam int MAX_BREAK  = (FIRST_BREAK > SECOND_BREAK) ?
      ((FIRST_BREAK > THIRD_BREAK) ? FIRST_BREAK : THIRD_BREAK) :
      ((SECOND_BREAK > THIRD_BREAK) ? SECOND_BREAK : THIRD_BREAK);
   localparam int QUOT_INT_W = $clog2(MAX_BREAK) + 1;
   localparam int QUOT_W     = FRAC_BITS + QUOT_INT_W;

   logic signed [HEIGHT_W-1:0] height_min_ff, height_min_in;
   logic signed [HEIGHT_W-1:0] height_max_ff, height_max_in;
   logic [HEIGHT_W-1:0]        span_ff, span_in;

   // link i feeds cell i; link 0 is the front stage, link QUOT_W the last cell
   logic                link_valid [QUOT_W+1];
   logic                link_ready [QUOT_W+1];
   logic [HEIGHT_W-1:0] link_rem   [QUOT_W+1];
   logic [QUOT_W-1:0]   link_dq    [QUOT_W+1];
   token_type           link_tok   [QUOT_W+1];

   // csr writes; span is the divisor, loaded together with the height registers
   always_comb begin
      height_min_in = height_min_ff;
      height_max_in = height_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEIGHT_MIN: height_min_in = csr_wdata;
            CSR_HEIGHT_MAX: height_max_in = csr_wdata;
         endcase
      end
      span_in = height_max_in - height_min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_min_ff <= '0;
         height_max_ff <= '0;
         span_ff       <= '0;
      end else begin
         height_min_ff <= height_min_in;
         height_max_ff <= height_max_in;
         span_ff       <= span_in;
      end
   end

   // front: offset from the minimum, scaled by the group count
   hcr_front #(
      .GROUP_TOTAL (GROUP_TOTAL),
      .QUOT_INT_W  (QUOT_INT_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (req_tvalid),
      .up_ready       (req_tready),
      .up_height      (req_tdata[HEIGHT_W-1:0]),
      .up_has_color   (req_tuser),
      .up_given_color (req_tdata[HEIGHT_W+COLOR_W-1:HEIGHT_W]),
      .height_min     (height_min_ff),
      .height_max     (height_max_ff),
      .span           (span_ff),
      .dn_valid       (link_valid[0]),
      .dn_ready       (link_ready[0]),
      .dn_rem         (link_rem[0]),
      .dn_dq          (link_dq[0]),
      .dn_tok         (link_tok[0])
   );

   // divider row, most significant quotient bit first
   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      hcr_div_cell #(
         .QUOT_W (QUOT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .span     (span_ff),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_rem   (link_rem[i]),
         .up_dq    (link_dq[i]),
         .up_tok   (link_tok[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_rem   (link_rem[i+1]),
         .dn_dq    (link_dq[i+1]),
         .dn_tok   (link_tok[i+1])
      );
   end

   // shading: segment, reciprocal multiply, colour and output register
   hcr_shade #(
      .FIRST_BREAK  (FIRST_BREAK),
      .SECOND_BREAK (SECOND_BREAK),
      .THIRD_BREAK  (THIRD_BREAK),
      .QUOT_W       (QUOT_W)
   ) u_shade (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (link_valid[QUOT_W]),
      .up_ready  (link_ready[QUOT_W]),
      .up_quot   (link_dq[QUOT_W]),
      .up_tok    (link_tok[QUOT_W]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_rgb   (rsp_tdata)
   );

endmodule
